// ----- design/tbcd_pkg.sv -----
// shared types and constants of the two-byte command decoder
`timescale 1ns / 1ps
`default_nettype none

package tbcd_pkg;

  typedef enum logic [2:0] {
    KIND_HIGH     = 3'd0,
    KIND_LED      = 3'd1,
    KIND_ENABLE   = 3'd2,
    KIND_DISABLE  = 3'd3,
    KIND_SERVO    = 3'd4,
    KIND_GOAL     = 3'd5,
    KIND_RESERVED = 3'd6
  } kind_t;

  localparam logic [13:0] CMD_LED_BASE = 14'h3FF8;
  localparam logic [13:0] CMD_ENABLE   = 14'h3F80;
  localparam logic [13:0] CMD_DISABLE  = 14'h3F00;
  localparam logic [13:0] SERVO_TOP    = 14'd2200;
  localparam logic [13:0] SERVO_BASE   = 14'd2000;
  localparam logic [13:0] GOAL_TOP     = 14'd1600;
  localparam logic [13:0] GOAL_OFFSET  = 14'd800;

  localparam logic signed [14:0] SERVO_MID    = 15'sd2100;
  localparam logic signed [14:0] SERVO_SPAN   = 15'sd100;
  localparam logic signed [14:0] PULSE_CENTER = 15'sd149;

  localparam logic [7:0] HIGH_MARK = 8'h80;
  localparam logic [6:0] LOW_MASK  = 7'h7F;

  localparam logic [7:0] PULSE_RESET = 8'd149;

  // decoded command handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [10:0] arg;   // led code, servo pulse or motor goal
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- design/tbcd_in_if.sv -----
// input channel: received serial bytes
`timescale 1ns / 1ps
`default_nettype none

interface tbcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- design/tbcd_out_if.sv -----
// output channel: one result item per received byte
`timescale 1ns / 1ps
`default_nettype none

interface tbcd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command_kind;
  logic [3:0]         led_bits;
  logic               loop_enabled;
  logic [7:0]         servo_pulse;
  logic signed [10:0] motor_goal;

  modport source (output valid, output command_kind, output led_bits, output loop_enabled,
                  output servo_pulse, output motor_goal, input ready);
  modport sink   (input valid, input command_kind, input led_bits, input loop_enabled,
                  input servo_pulse, input motor_goal, output ready);
endinterface

`default_nettype wire

// ----- design/tbcd_front.sv -----
// front end: joins byte halves and classifies the command
`timescale 1ns / 1ps
`default_nettype none

module tbcd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  tbcd_in_if.sink                   in_ch,
  input  wire tbcd_pkg::q_status_t  q_stat,
  output tbcd_pkg::cmd_t            push_data,
  output logic                      push
);

  logic [6:0]         pending_high;
  logic [13:0]        cmd;
  logic signed [14:0] off;
  logic signed [14:0] off_clamped;
  logic signed [14:0] pulse_wide;
  logic [13:0]        goal_wide;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  assign cmd = {pending_high, in_ch.rx_byte[6:0] & tbcd_pkg::LOW_MASK};

  always_comb begin
    off = $signed({1'b0, cmd}) - tbcd_pkg::SERVO_MID;
    if (off < -tbcd_pkg::SERVO_SPAN) begin
      off_clamped = -tbcd_pkg::SERVO_SPAN;
    end else if (off > tbcd_pkg::SERVO_SPAN) begin
      off_clamped = tbcd_pkg::SERVO_SPAN;
    end else begin
      off_clamped = off;
    end
    pulse_wide = off_clamped + tbcd_pkg::PULSE_CENTER;
    goal_wide  = cmd - tbcd_pkg::GOAL_OFFSET;
  end

  always_comb begin
    push_data.arg = {8'd0, cmd[2:0]};
    if ((in_ch.rx_byte & tbcd_pkg::HIGH_MARK) != 8'd0) begin
      push_data.kind = tbcd_pkg::KIND_HIGH;
    end else if (cmd >= tbcd_pkg::CMD_LED_BASE) begin
      push_data.kind = tbcd_pkg::KIND_LED;
    end else if (cmd >= tbcd_pkg::CMD_ENABLE) begin
      push_data.kind = tbcd_pkg::KIND_ENABLE;
    end else if (cmd >= tbcd_pkg::CMD_DISABLE) begin
      push_data.kind = tbcd_pkg::KIND_DISABLE;
    end else if (cmd >= tbcd_pkg::SERVO_TOP) begin
      push_data.kind = tbcd_pkg::KIND_RESERVED;
    end else if (cmd >= tbcd_pkg::SERVO_BASE) begin
      push_data.kind = tbcd_pkg::KIND_SERVO;
      push_data.arg  = {3'd0, pulse_wide[7:0]};
    end else if (cmd >= tbcd_pkg::GOAL_TOP) begin
      push_data.kind = tbcd_pkg::KIND_RESERVED;
    end else begin
      push_data.kind = tbcd_pkg::KIND_GOAL;
      push_data.arg  = goal_wide[10:0];
    end
  end

  // a low half leaves the stored high half in place
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high <= 7'd0;
    end else if (push && in_ch.rx_byte[7]) begin
      pending_high <= in_ch.rx_byte[6:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/tbcd_queue.sv -----
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tbcd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire tbcd_pkg::cmd_t       push_data,
  input  wire logic                 pop,
  output tbcd_pkg::cmd_t            pop_data,
  output tbcd_pkg::q_status_t       q_stat
);

  tbcd_pkg::cmd_t mem [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign pop_data     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
                              (count == 2'd0 || count == 2'd2) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- design/tbcd_back.sv -----
// back end: applies commands to the state and registers the result item
`timescale 1ns / 1ps
`default_nettype none

module tbcd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tbcd_pkg::q_status_t  q_stat,
  input  wire tbcd_pkg::cmd_t       pop_data,
  output logic                      pop,
  tbcd_out_if.source                out_ch
);

  logic               out_valid;
  logic [3:0]         led_state;
  logic               enable_flag;
  logic [7:0]         pulse_reg;
  logic [10:0]        goal_reg;
  logic [3:0]         led_state_next;
  logic               enable_flag_next;
  logic [7:0]         pulse_reg_next;
  logic [10:0]        goal_reg_next;
  logic [3:0]         led_bit;

  assign pop          = !q_stat.empty && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;
  assign led_bit      = 4'b0001 << pop_data.arg[1:0];

  always_comb begin
    led_state_next   = led_state;
    enable_flag_next = enable_flag;
    pulse_reg_next   = pulse_reg;
    goal_reg_next    = goal_reg;
    case (pop_data.kind)
      tbcd_pkg::KIND_LED: begin
        if (pop_data.arg[2]) begin
          led_state_next = led_state | led_bit;
        end else begin
          led_state_next = led_state & ~led_bit;
        end
      end
      tbcd_pkg::KIND_ENABLE:  enable_flag_next = 1'b1;
      tbcd_pkg::KIND_DISABLE: enable_flag_next = 1'b0;
      tbcd_pkg::KIND_SERVO:   pulse_reg_next   = pop_data.arg[7:0];
      tbcd_pkg::KIND_GOAL:    goal_reg_next    = pop_data.arg;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      led_state   <= 4'd0;
      enable_flag <= 1'b0;
      pulse_reg   <= tbcd_pkg::PULSE_RESET;
      goal_reg    <= 11'd0;
    end else begin
      if (pop) begin
        out_valid   <= 1'b1;
        led_state   <= led_state_next;
        enable_flag <= enable_flag_next;
        pulse_reg   <= pulse_reg_next;
        goal_reg    <= goal_reg_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload shows the state after the item
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.command_kind <= pop_data.kind;
      out_ch.led_bits     <= led_state_next;
      out_ch.loop_enabled <= enable_flag_next;
      out_ch.servo_pulse  <= pulse_reg_next;
      out_ch.motor_goal   <= $signed(goal_reg_next);
    end
  end

endmodule

`default_nettype wire

// ----- design/two_byte_command_decoder_unit.sv -----
// top level of the two-byte command decoder
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per cycle while the queue is not full and returns one result
// item per byte, in order. A byte is classified on entry, held in a two-entry queue and
// applied to the LED, enable, servo and motor goal registers by the back end, whose output
// register shows the kind of the item and the state after it. An accepted byte is written
// into the queue, then into the output register; sustained rate is one item per cycle
// while the output is ready, set by the combinational decode in front and the registered
// state update in the back. A stalled output fills the queue, then holds off the input.
module two_byte_command_decoder_unit (
  input  wire logic clk,
  input  wire logic rst,
  tbcd_in_if.sink   in_ch,
  tbcd_out_if.source out_ch
);

  tbcd_pkg::cmd_t      push_data;
  tbcd_pkg::cmd_t      pop_data;
  tbcd_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;

  tbcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push_data (push_data),
    .push      (push)
  );

  tbcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  tbcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- verif/two_byte_command_decoder_unit_tb.sv -----
// self-checking testbench of the two-byte command decoder: directed table, then random bytes
`timescale 1ns / 1ps

module two_byte_command_decoder_unit_tb;

  typedef struct packed {
    tbcd_pkg::kind_t kind;
    logic [3:0]      leds;
    logic            enabled;
    logic [7:0]      pulse;
    logic [10:0]     goal;
  } decode_result_t;

  typedef struct packed {
    logic [7:0]     rx;
    logic           typed;
    decode_result_t want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 28;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 13;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   errors = 0;
  int   cycle_count = 0;

  tbcd_in_if  in_ch ();
  tbcd_out_if out_ch ();

  two_byte_command_decoder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted decoder state
  logic [6:0]  pend_high;
  logic [3:0]  led_now;
  logic        en_now;
  logic [7:0]  pulse_now;
  logic [10:0] goal_now;

  decode_result_t expected_q [$];
  decode_result_t got;
  decode_result_t want;
  stim_row_t      directed_rows [DIRECTED_ROWS];

  function automatic string show(input decode_result_t r);
    return $sformatf("kind %0d leds %h en %b pulse %0d goal %0d",
                     r.kind, r.leds, r.enabled, r.pulse, $signed(r.goal));
  endfunction

  function automatic decode_result_t apply_byte(input logic [7:0] b);
    logic [13:0]    cmd;
    int             off;
    decode_result_t r;
    r.kind = tbcd_pkg::KIND_HIGH;
    if (b[7]) begin
      pend_high = b[6:0];
    end else begin
      cmd = {pend_high, b[6:0]};
      if (cmd >= tbcd_pkg::CMD_LED_BASE) begin
        // code bit 2 selects on, the low two bits pick the led
        led_now[cmd[1:0]] = cmd[2];
        r.kind = tbcd_pkg::KIND_LED;
      end else if (cmd >= tbcd_pkg::CMD_ENABLE) begin
        en_now = 1'b1;
        r.kind = tbcd_pkg::KIND_ENABLE;
      end else if (cmd >= tbcd_pkg::CMD_DISABLE) begin
        en_now = 1'b0;
        r.kind = tbcd_pkg::KIND_DISABLE;
      end else if (cmd >= tbcd_pkg::SERVO_TOP) begin
        r.kind = tbcd_pkg::KIND_RESERVED;
      end else if (cmd >= tbcd_pkg::SERVO_BASE) begin
        off = int'(cmd) - int'(tbcd_pkg::SERVO_MID);
        if (off < -int'(tbcd_pkg::SERVO_SPAN)) off = -int'(tbcd_pkg::SERVO_SPAN);
        if (off > int'(tbcd_pkg::SERVO_SPAN)) off = int'(tbcd_pkg::SERVO_SPAN);
        pulse_now = 8'(off + int'(tbcd_pkg::PULSE_CENTER));
        r.kind = tbcd_pkg::KIND_SERVO;
      end else if (cmd >= tbcd_pkg::GOAL_TOP) begin
        r.kind = tbcd_pkg::KIND_RESERVED;
      end else begin
        goal_now = 11'(int'(cmd) - int'(tbcd_pkg::GOAL_OFFSET));
        r.kind = tbcd_pkg::KIND_GOAL;
      end
    end
    r.leds    = led_now;
    r.enabled = en_now;
    r.pulse   = pulse_now;
    r.goal    = goal_now;
    return r;
  endfunction

  function automatic logic [13:0] pick_command();
    case ($urandom_range(0, 6))
      0: return tbcd_pkg::CMD_LED_BASE + 14'($urandom_range(0, 7));
      1: return tbcd_pkg::CMD_ENABLE +
                14'($urandom_range(0, tbcd_pkg::CMD_LED_BASE - tbcd_pkg::CMD_ENABLE - 1));
      2: return tbcd_pkg::CMD_DISABLE +
                14'($urandom_range(0, tbcd_pkg::CMD_ENABLE - tbcd_pkg::CMD_DISABLE - 1));
      3: return 14'($urandom_range(tbcd_pkg::SERVO_TOP, tbcd_pkg::CMD_DISABLE - 1));
      4: return 14'($urandom_range(tbcd_pkg::SERVO_BASE, tbcd_pkg::SERVO_TOP - 1));
      5: return 14'($urandom_range(tbcd_pkg::GOAL_TOP, tbcd_pkg::SERVO_BASE - 1));
      default: return 14'($urandom_range(0, tbcd_pkg::GOAL_TOP - 1));
    endcase
  endfunction

  function automatic stim_row_t row_p(input logic [7:0] rx);
    stim_row_t s;
    s = '0;
    s.rx = rx;
    return s;
  endfunction

  function automatic stim_row_t row_t(input logic [7:0] rx, input tbcd_pkg::kind_t kind,
                                      input logic [3:0] leds, input logic enabled,
                                      input logic [7:0] pulse, input int goal);
    stim_row_t s;
    s.rx    = rx;
    s.typed = 1'b1;
    s.want  = '{kind: kind, leds: leds, enabled: enabled, pulse: pulse, goal: 11'(goal)};
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input decode_result_t fixed);
    decode_result_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = apply_byte(b);
    expected_q.push_back(typed ? fixed : pred);
  endtask

  // result side: random back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{kind: tbcd_pkg::kind_t'(out_ch.command_kind), leds: out_ch.led_bits,
              enabled: out_ch.loop_enabled, pulse: out_ch.servo_pulse,
              goal: out_ch.motor_goal};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item %s", $time, show(got));
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected %s, got %s", $time, show(want), show(got));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_byte_command_decoder_unit verification failed");
      $finish;
    end
  end

  initial begin
    int             sent;
    int             pick;
    int             extra;
    logic [13:0]    cmd;
    decode_result_t blank;
    rst           = 1'b1;
    calm          = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    blank         = '0;
    pend_high     = '0;
    led_now       = '0;
    en_now        = 1'b0;
    pulse_now     = tbcd_pkg::PULSE_RESET;
    goal_now      = '0;

    directed_rows = '{
      row_t(8'h00, tbcd_pkg::KIND_GOAL, 4'h0, 1'b0, 8'd149, -800),  // lone low half after reset
      row_p(8'h8C),
      row_t(8'h3F, tbcd_pkg::KIND_GOAL, 4'h0, 1'b0, 8'd149, 799),
      row_t(8'h40, tbcd_pkg::KIND_RESERVED, 4'h0, 1'b0, 8'd149, 799),
      row_p(8'h8F),
      row_p(8'h4F),
      row_t(8'h50, tbcd_pkg::KIND_SERVO, 4'h0, 1'b0, 8'd49, 799),
      row_p(8'h91),
      row_t(8'h17, tbcd_pkg::KIND_SERVO, 4'h0, 1'b0, 8'd248, 799),
      row_p(8'h18),
      row_p(8'h90),
      row_p(8'h34),
      row_p(8'hFD),
      row_p(8'h7F),
      row_p(8'hFF),
      row_t(8'h00, tbcd_pkg::KIND_ENABLE, 4'h0, 1'b1, 8'd149, 799),
      row_p(8'h7C),                                           // high half kept from here until the 8'hFE byte
      row_p(8'h7D),
      row_p(8'h7E),
      row_t(8'h7F, tbcd_pkg::KIND_LED, 4'hF, 1'b1, 8'd149, 799),
      row_p(8'h78),
      row_p(8'h79),
      row_p(8'h7A),
      row_t(8'h7B, tbcd_pkg::KIND_LED, 4'h0, 1'b1, 8'd149, 799),
      row_p(8'h77),
      row_p(8'hFE),
      row_p(8'h7F),
      row_t(8'h00, tbcd_pkg::KIND_DISABLE, 4'h0, 1'b0, 8'd149, 799)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm <= (sent >= 700 && sent < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // well-formed command, sometimes followed by low halves reusing its high half
        cmd = pick_command();
        send_byte({1'b1, cmd[13:7]}, 1'b0, blank);
        send_byte({1'b0, cmd[6:0]}, 1'b0, blank);
        sent += 2;
        if (pick < 20) begin
          extra = $urandom_range(1, 3);
          for (int k = 0; k < extra; k++)
            send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0, blank);
          sent += extra;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, blank);
        sent++;
      end
    end

    calm        <= 1'b0;
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("two_byte_command_decoder_unit verification clean");
    end else begin
      $display("two_byte_command_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
